// ===== hdl/fpcc_pkg.sv =====
// Package: shared types and constants for the convert-and-compare unit.
`default_nettype none
package fpcc_pkg;
    localparam logic [31:0] C_WORD_SAT = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        RM_NEAREST = 2'd0,
        RM_ZERO    = 2'd1,
        RM_PLUS    = 2'd2,
        RM_MINUS   = 2'd3
    } t_round_mode;

    typedef enum logic {
        OP_CVT = 1'b0,
        OP_CMP = 1'b1
    } t_op;

    typedef struct packed {
        logic        operation;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [3:0]  compare_condition;
    } t_request;

    typedef struct packed {
        logic signed [31:0] word_result;
        logic               condition_flag;
    } t_result;
endpackage
`default_nettype wire

// ===== hdl/fp_convert_and_compare_unit.sv =====
// Top level: convert-and-compare unit with input and result registers.
// Path from start to o_valid: input register, then result register.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// Reset: synchronous active low; clears valids, condition bit and rounding mode.
`default_nettype none
module fp_convert_and_compare_unit
    import fpcc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_request i_request,
    output logic          o_valid,
    output t_result       o_result,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic [1:0] i_cfg_data
);
    logic     r_in_valid;
    t_request r_in;
    logic [1:0] r_mode;
    logic     r_cond;
    logic     n_cond;
    logic [31:0] cvt_word;
    logic     cmp_flag;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    fpcc_cvt u_cvt (.i_x(r_in.operand_a), .i_mode(r_mode), .o_word(cvt_word));
    fpcc_cmp u_cmp (.i_a(r_in.operand_a), .i_b(r_in.operand_b),
                    .i_cond(r_in.compare_condition), .o_flag(cmp_flag));

    assign n_cond = (r_in_valid && r_in.operation == OP_CMP) ? cmp_flag : r_cond;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            o_valid    <= 1'b0;
            r_mode     <= RM_NEAREST;
            r_cond     <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            o_valid    <= r_in_valid;
            r_cond     <= n_cond;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_request;
        end
        if (r_in_valid) begin
            o_result.word_result    <= (r_in.operation == OP_CMP) ? 32'sd0 : cvt_word;
            o_result.condition_flag <= n_cond;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/fpcc_cvt.sv =====
// Convert: binary32 to signed 32-bit word with configurable rounding.
`default_nettype none
module fpcc_cvt
    import fpcc_pkg::*;
(
    input  wire logic [31:0] i_x,
    input  wire logic [1:0]  i_mode,
    output logic [31:0]      o_word
);
    logic [7:0]  ex;
    logic        neg;
    logic [23:0] mant;
    logic [55:0] wide;
    logic [31:0] mag;
    logic [32:0] mag_r;
    logic [23:0] rem;
    logic        half_bit;
    logic        sticky;
    logic        lsb;
    logic        up;
    logic [7:0]  sh;

    always_comb begin
        ex      = i_x[30:23];
        neg     = i_x[31];
        mant    = {1'b1, i_x[22:0]};
        sh      = 8'd0;
        wide    = '0;
        mag     = '0;
        rem     = '0;
        up      = 1'b0;
        mag_r   = '0;
        o_word  = '0;
        if (ex >= 8'd150) begin
            sh    = ex - 8'd150;
            mag_r = {1'b0, 32'(({8'd0, mant}) << sh[3:0])};
        end else begin
            sh   = 8'd150 - ex;
            // place mantissa above 24 zero fraction bits; shift right by sh keeps 24 fraction bits
            wide = (sh > 8'd25) ? 56'd1 : ({8'd0, mant, 24'd0} >> sh[4:0]);
            mag  = wide[55:24];
            rem  = wide[23:0];
        end
        half_bit = rem[23];
        sticky   = |rem[22:0];
        lsb      = mag[0];
        case (t_round_mode'(i_mode))
            RM_NEAREST: up = half_bit && (sticky || lsb);
            RM_ZERO:    up = 1'b0;
            RM_PLUS:    up = !neg && (half_bit || sticky);
            RM_MINUS:   up = neg && (half_bit || sticky);
            default:    up = 1'b0;
        endcase
        if (ex < 8'd150) begin
            mag_r = {1'b0, mag} + {32'd0, up};
        end
        if (ex == 8'hFF || ex > 8'd158) begin
            o_word = C_WORD_SAT;
        end else if (ex == 8'd0) begin
            o_word = '0;
        end else if (neg) begin
            o_word = (mag_r > 33'h0_8000_0000) ? C_WORD_SAT : (32'd0 - mag_r[31:0]);
        end else begin
            o_word = (mag_r > 33'h0_7FFF_FFFF) ? C_WORD_SAT : mag_r[31:0];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/fpcc_cmp.sv =====
// Compare: evaluate a condition code on two binary32 operands.
`default_nettype none
module fpcc_cmp
    import fpcc_pkg::*;
(
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [3:0]  i_cond,
    output logic             o_flag
);
    logic nan_a, nan_b, unord, zero_a, zero_b, less, equal, mag_lt;

    always_comb begin
        nan_a  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != '0);
        nan_b  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != '0);
        unord  = nan_a || nan_b;
        zero_a = (i_a[30:23] == 8'd0);
        zero_b = (i_b[30:23] == 8'd0);
        mag_lt = i_a[30:0] < i_b[30:0];
        if (zero_a && zero_b) begin
            less  = 1'b0;
            equal = 1'b1;
        end else if (zero_a) begin
            less  = !i_b[31];
            equal = 1'b0;
        end else if (zero_b) begin
            less  = i_a[31];
            equal = 1'b0;
        end else begin
            equal = (i_a == i_b);
            if (i_a[31] != i_b[31]) begin
                less = i_a[31];
            end else if (i_a[31]) begin
                less = !mag_lt && !equal;
            end else begin
                less = mag_lt;
            end
        end
        o_flag = (i_cond[2] && less && !unord) || (i_cond[1] && equal && !unord)
               || (i_cond[0] && unord);
    end
endmodule
`default_nettype wire

// ===== hdl/fpcc_checker.sv =====
// Checker: port-level properties of the convert-and-compare unit.
`default_nettype none
module fpcc_checker
    import fpcc_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire t_request i_request,
    input wire logic     o_valid,
    input wire t_result  o_result
);
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_valid) else $error("missing result");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2)) else $error("spurious result");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_request.operation == OP_CMP, 2) |-> o_result.word_result == 0)
        else $error("compare word nonzero");
    a_cvt_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) && $past(i_request.operation == OP_CVT, 2)
        |-> $stable(o_result.condition_flag)) else $error("convert changed flag");
endmodule

bind fp_convert_and_compare_unit fpcc_checker u_fpcc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_request(i_request), .o_valid(o_valid), .o_result(o_result)
);
`default_nettype wire

// ===== tb/tb_fp_convert_and_compare_unit.sv =====
// Testbench: checks the convert-and-compare unit against a behavioral predictor.
`timescale 1ns / 1ps
module tb_fp_convert_and_compare_unit;
    import fpcc_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_request;
    logic     o_valid;
    t_result  o_result;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    logic [1:0] i_cfg_data;

    fp_convert_and_compare_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_request(i_request), .o_valid(o_valid), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    t_request    pending_requests[$];
    int          pending_gaps[$];
    t_result     expected_results[$];
    t_round_mode round_mode;
    logic        cond_bit;
    int          errors;
    int          idle_cycles;
    int          gap_left;
    logic        cfg_pending;
    t_round_mode cfg_value;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] convert_to_word(logic [31:0] x, t_round_mode rm);
        logic [7:0]  ex;
        logic        neg;
        logic [63:0] mant;
        logic [63:0] mag;
        logic [63:0] rem;
        logic [63:0] half;
        logic        up;
        int          sh;
        ex = x[30:23];
        neg = x[31];
        up = 1'b0;
        if (ex == 8'hFF) return C_WORD_SAT;
        if (ex == 8'h00) return 32'd0;
        mant = {40'd0, 1'b1, x[22:0]};
        if (ex >= 150) begin
            if (ex > 158) return C_WORD_SAT;
            mag = mant << (ex - 150);
        end else begin
            sh = 150 - ex;
            if (sh > 25) begin
                mag = 0;
                rem = 1;
                half = 2;
            end else begin
                mag = mant >> sh;
                rem = mant & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
            end
            case (rm)
                RM_NEAREST: up = (rem > half) || (rem == half && mag[0]);
                RM_ZERO:    up = 1'b0;
                RM_PLUS:    up = !neg && rem != 0;
                default:    up = neg && rem != 0;
            endcase
            if (up) mag = mag + 1;
        end
        if (neg) begin
            if (mag > 64'h8000_0000) return C_WORD_SAT;
            return 32'd0 - mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF) return C_WORD_SAT;
        return mag[31:0];
    endfunction

    function automatic logic is_nan(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic longint order_key(logic [31:0] x);
        longint m;
        m = longint'(x[30:0]);
        if (x[30:23] == 8'h00) return 0;
        return x[31] ? -m : m;
    endfunction

    task automatic predict_result(t_request r);
        t_result res;
        logic    unord;
        longint  ka;
        longint  kb;
        res.word_result = '0;
        if (r.operation == OP_CVT) begin
            res.word_result = convert_to_word(r.operand_a, round_mode);
        end else begin
            unord = is_nan(r.operand_a) || is_nan(r.operand_b);
            ka = order_key(r.operand_a);
            kb = order_key(r.operand_b);
            cond_bit = (r.compare_condition[2] && !unord && ka < kb) ||
                       (r.compare_condition[1] && !unord && ka == kb) ||
                       (r.compare_condition[0] && unord);
        end
        res.condition_flag = cond_bit;
        expected_results.push_back(res);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                predict_result(i_request);
                void'(pending_requests.pop_front());
                void'(pending_gaps.pop_front());
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                if (pending_requests.size() > 0) begin
                    if (start && !busy && pending_gaps[0] > 0) begin
                        start <= 1'b0;
                        gap_left <= pending_gaps[0] - 1;
                    end else begin
                        start <= 1'b1;
                        i_request <= pending_requests[0];
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // config writer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            round_mode <= t_round_mode'(i_cfg_data);
            i_cfg_valid <= 1'b0;
            cfg_pending <= 1'b0;
        end else if (cfg_pending) begin
            i_cfg_valid <= 1'b1;
            i_cfg_data <= cfg_value;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word_result=%h", o_result.word_result);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.word_result !== want.word_result) begin
                    $error("word_result expected %h actual %h",
                           want.word_result, o_result.word_result);
                    errors++;
                end
                if (o_result.condition_flag !== want.condition_flag) begin
                    $error("condition_flag expected %b actual %b",
                           want.condition_flag, o_result.condition_flag);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 2000) begin
                $display("tb_fp_convert_and_compare_unit: FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 9))
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'h00;
            2, 3, 4, 5: f[30:23] = $urandom_range(118, 160);
            6: f[30:0] = 0;
            default: ;
        endcase
        return f;
    endfunction

    task automatic add_request(t_op op, logic [31:0] a, logic [31:0] b, logic [3:0] c,
                               logic random_gap);
        t_request r;
        r.operation = op;
        r.operand_a = a;
        r.operand_b = b;
        r.compare_condition = c;
        pending_requests.push_back(r);
        pending_gaps.push_back(random_gap && $urandom_range(0, 3) == 0 ?
                               $urandom_range(0, 11) : 0);
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_round_mode(t_round_mode m);
        cfg_value = m;
        cfg_pending = 1'b1;
        while (cfg_pending) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic directed_requests();
        add_request(OP_CVT, 32'h3FC0_0000, 0, 0, 0);
        add_request(OP_CVT, 32'hC020_0000, 0, 0, 0);
        add_request(OP_CVT, 32'h4F00_0000, 0, 0, 0);
        add_request(OP_CVT, 32'hCF00_0000, 0, 0, 0);
        add_request(OP_CVT, 32'hCF00_0001, 0, 0, 0);
        add_request(OP_CVT, 32'h7F80_0000, 0, 0, 0);
        add_request(OP_CVT, 32'hFFC0_0001, 0, 0, 0);
        add_request(OP_CVT, 32'h0000_0001, 0, 0, 0);
        add_request(OP_CVT, 32'h8000_0000, 0, 0, 0);
        add_request(OP_CVT, 32'h3F00_0000, 0, 0, 0);
        add_request(OP_CVT, 32'hBE80_0000, 0, 0, 0);
        add_request(OP_CVT, 32'h0080_0000, 0, 0, 0);
        add_request(OP_CMP, 32'h0000_0000, 32'h8000_0000, 4'hF, 0);
        add_request(OP_CMP, 32'h0000_0005, 32'h8000_0000, 4'h2, 0);
        add_request(OP_CMP, 32'h7FC0_0000, 32'h3F80_0000, 4'h1, 0);
        add_request(OP_CMP, 32'h7FC0_0000, 32'h3F80_0000, 4'h6, 0);
        add_request(OP_CMP, 32'hBF80_0000, 32'h3F80_0000, 4'h4, 0);
        add_request(OP_CMP, 32'h3F80_0000, 32'hBF80_0000, 4'hC, 0);
        add_request(OP_CVT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 0);
    endtask

    initial begin
        t_round_mode m;
        logic [31:0] a;
        errors = 0;
        round_mode = RM_NEAREST;
        cond_bit = 1'b0;
        cfg_pending = 1'b0;
        cfg_value = RM_NEAREST;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_request = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        gap_left = 0;
        idle_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            m = t_round_mode'(k);
            set_round_mode(m);
            directed_requests();
            drain();
        end
        for (int p = 0; p < 8; p++) begin
            m = t_round_mode'(p == 0 ? RM_MINUS : $urandom_range(0, 3));
            set_round_mode(m);
            for (int n = 0; n < 150; n++) begin
                a = pick_float();
                add_request($urandom_range(0, 1) ? OP_CMP : OP_CVT, a,
                            $urandom_range(0, 3) == 0 ? a : pick_float(),
                            $urandom_range(0, 15), 1);
            end
            drain();
        end
        if (errors == 0) begin
            $display("tb_fp_convert_and_compare_unit: PASS");
        end else begin
            $display("tb_fp_convert_and_compare_unit: FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/fpcc_pkg.sv
hdl/fpcc_cvt.sv
hdl/fpcc_cmp.sv
hdl/fp_convert_and_compare_unit.sv
hdl/fpcc_checker.sv
tb/tb_fp_convert_and_compare_unit.sv
